// ----- design/assert_macros.svh -----
// Assertion macros used by the filter module.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition holds whenever an enable is high.
`define ASSERT_WHEN(label, en, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (en) |-> (cond)) else $error(msg);

`endif

// ----- design/goef_pkg.sv -----
// Types, sizes and codes for the overlap and energy filter.
// No dependencies; used by goef_dist and greedy_overlap_energy_filter.
package goef_pkg;

  localparam int KEPT_DEPTH = 1024;
  localparam int ADDR_W     = (KEPT_DEPTH > 1) ? $clog2(KEPT_DEPTH) : 1;
  localparam int CNT_W      = $clog2(KEPT_DEPTH + 1);
  localparam int POS_W      = 25;
  localparam int EN_W       = 21;
  localparam int CSQ_W      = 40;
  localparam int TOTAL_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;
  localparam int SQ_W       = 2 * POS_W;
  localparam int SUM_W      = SQ_W + 2;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [EN_W-1:0]  energy_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
  } kept_pos_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } dist_stat_t;

  typedef enum logic [1:0] {
    MODE_DIST   = 2'd0,
    MODE_ENERGY = 2'd1,
    MODE_BOTH   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    VERDICT_KEPT    = 2'd0,
    VERDICT_ENERGY  = 2'd1,
    VERDICT_OVERLAP = 2'd2,
    VERDICT_FULL    = 2'd3
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_ELIMIT  = 2'd1,
    CFG_CONTACT = 2'd2
  } cfg_reg_t;

endpackage

// ----- design/goef_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module goef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/goef_dist.sv -----
// Pipelined squared-distance compare of a candidate against one kept position.
// Depends on goef_pkg. Stages: abs difference, square, sum, compare.
module goef_dist
  import goef_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req,
  input  kept_pos_t        cand,
  input  kept_pos_t        kept,
  input  logic [CSQ_W-1:0] contact_sq,
  output dist_stat_t       stat
);

  logic                  s1_v, s2_v, s3_v, s4_v;
  logic [POS_W-1:0]      ad_x, ad_y, ad_z;
  logic [SQ_W-1:0]       sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]      sum;
  logic                  s4_hit;
  logic signed [POS_W:0] d_x, d_y, d_z;
  logic [POS_W:0]        n_x, n_y, n_z;

  assign d_x = {cand.x[POS_W-1], cand.x} - {kept.x[POS_W-1], kept.x};
  assign d_y = {cand.y[POS_W-1], cand.y} - {kept.y[POS_W-1], kept.y};
  assign d_z = {cand.z[POS_W-1], cand.z} - {kept.z[POS_W-1], kept.z};
  assign n_x = d_x[POS_W] ? (~d_x + 1'b1) : d_x;
  assign n_y = d_y[POS_W] ? (~d_y + 1'b1) : d_y;
  assign n_z = d_z[POS_W] ? (~d_z + 1'b1) : d_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= req;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
    ad_x   <= n_x[POS_W-1:0];
    ad_y   <= n_y[POS_W-1:0];
    ad_z   <= n_z[POS_W-1:0];
    sq_x   <= ad_x * ad_x;
    sq_y   <= ad_y * ad_y;
    sq_z   <= ad_z * ad_z;
    sum    <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
    s4_hit <= sum < SUM_W'(contact_sq);
  end

  assign stat.busy = s1_v | s2_v | s3_v | s4_v;
  assign stat.hit  = s4_v & s4_hit;

endmodule

// ----- design/greedy_overlap_energy_filter.sv -----
// Greedy overlap and energy filter for candidate water positions. Each candidate
// transfer gets one result transfer. A candidate that needs the distance test is
// compared against every kept position, one memory entry per cycle through the
// single read port, until the set is done or an overlap ends the scan early; one
// that needs no scan (energy failure, energy-only mode or empty set) goes
// straight to the finish state. The next candidate is taken while an earlier
// result still waits on the output.
// Depends on goef_pkg, goef_ram, goef_dist and assert_macros.svh.
`include "assert_macros.svh"

module greedy_overlap_energy_filter
  import goef_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [24:0]    pos_x,
  input  logic signed [24:0]    pos_y,
  input  logic signed [24:0]    pos_z,
  input  logic signed [20:0]    energy,
  input  logic                  last_of_set,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  keep,
  output logic [1:0]            verdict,
  output logic [TOTAL_W-1:0]    kept_total
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t             state;
  logic [1:0]         mode;
  energy_t            energy_limit;
  logic [CSQ_W-1:0]   contact_sq;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   rd_idx;
  logic               rd_pending;
  logic               hit_seen;
  logic               energy_fail;
  logic               cur_last;
  kept_pos_t          cand;
  kept_pos_t          rd_data;
  dist_stat_t         dstat;
  logic               use_energy, use_dist, e_fail, rd_en, scan_done, out_free;
  logic               wr_en;
  verdict_t           verdict_next;
  logic [CNT_W-1:0]   count_next;
  logic [TOTAL_W+CNT_W-1:0] total_wide;

  assign use_energy = mode != MODE_DIST;
  assign use_dist   = mode != MODE_ENERGY;
  assign e_fail     = use_energy && !(energy < energy_limit);
  assign in_ready   = state == ST_IDLE;
  assign rd_en      = (state == ST_SCAN) && (rd_idx < count) && !hit_seen;
  assign scan_done  = ((rd_idx == count) || hit_seen) && !rd_pending && !dstat.busy;
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    if (energy_fail) begin
      verdict_next = VERDICT_ENERGY;
    end else if (hit_seen) begin
      verdict_next = VERDICT_OVERLAP;
    end else if (count >= CNT_W'(KEPT_DEPTH)) begin
      verdict_next = VERDICT_FULL;
    end else begin
      verdict_next = VERDICT_KEPT;
    end
  end

  assign wr_en      = (state == ST_FINISH) && out_free && (verdict_next == VERDICT_KEPT);
  assign count_next = wr_en ? count + 1'b1 : count;
  assign total_wide = {{TOTAL_W{1'b0}}, count_next};

  goef_ram #(
    .WIDTH($bits(kept_pos_t)),
    .DEPTH(KEPT_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (cand),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  goef_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .req        (rd_pending),
    .cand       (cand),
    .kept       (rd_data),
    .contact_sq (contact_sq),
    .stat       (dstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_BOTH;
      energy_limit <= -21'sd1000;
      contact_sq   <= 40'd5290000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:    mode         <= cfg_data[1:0];
        CFG_ELIMIT:  energy_limit <= cfg_data[EN_W-1:0];
        CFG_CONTACT: contact_sq   <= cfg_data[CSQ_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      rd_pending <= 1'b0;
      hit_seen   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= rd_en;
      if (out_valid && out_ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            hit_seen <= 1'b0;
            rd_idx   <= '0;
            if (!e_fail && use_dist && (count != '0)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (dstat.hit) begin
            hit_seen <= 1'b1;
          end
          if (scan_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            keep       <= verdict_next == VERDICT_KEPT;
            verdict    <= verdict_next;
            kept_total <= total_wide[TOTAL_W-1:0];
            count      <= cur_last ? '0 : count_next;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
    if (in_valid && in_ready) begin
      cand.x      <= pos_x;
      cand.y      <= pos_y;
      cand.z      <= pos_z;
      cur_last    <= last_of_set;
      energy_fail <= e_fail;
    end
  end

  `ASSERT_CLK(a_count_range, count <= CNT_W'(KEPT_DEPTH), "kept count beyond store depth")
  `ASSERT_WHEN(a_read_written, rd_en, rd_idx < count, "read of an unwritten entry")
  `ASSERT_WHEN(a_keep_code, out_valid, keep == (verdict == VERDICT_KEPT), "keep disagrees with verdict")
  `ASSERT_CLK(a_count_step, wr_en && !cur_last |=> count == $past(count) + 1'b1, "count did not advance on store")

endmodule
